@@ rtl/utf8v_pkg.sv @@
// shared types, constants and helpers for the utf-8 validator with utf-16 unit count
package utf8v_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int UNITS_W   = 16;
    localparam int SCALAR_W  = 21;
    localparam int PEND_W    = 2;
    localparam int SEQLEN_W  = 3;

    // packed output data: status, unit_count, scalar_value, char_done, zero fill
    localparam int OUT_FIELDS_W = STATUS_W + UNITS_W + SCALAR_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_DATA_W    = BYTE_W;

    // reset value of the unit limit register
    localparam logic [UNITS_W-1:0] MAX_UNITS_RESET = 16'd50;

    // scalar limits
    localparam logic [SCALAR_W-1:0] SCALAR_MAX    = 21'h10FFFF;
    localparam logic [SCALAR_W-1:0] SURR_LOW      = 21'h00D800;
    localparam logic [SCALAR_W-1:0] SURR_HIGH     = 21'h00DFFF;
    localparam logic [SCALAR_W-1:0] BMP_MAX       = 21'h00FFFF;
    localparam logic [UNITS_W-1:0]  UNITS_SAT     = 16'hFFFF;

    // per-byte status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DONE     = 3'd1,
        ST_BAD_LEAD = 3'd2,
        ST_BAD_CONT = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_BAD_SCAL = 3'd5,
        ST_OVER     = 3'd6,
        ST_DISCARD  = 3'd7
    } status_t;

    // per-string decoder state
    typedef struct packed {
        logic [PEND_W-1:0]   pending;
        logic [SEQLEN_W-1:0] seq_len;
        logic [SCALAR_W-1:0] partial;
        logic [UNITS_W-1:0]  units;
        logic                failed;
    } str_state_t;

    // one accepted input byte
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    // one result
    typedef struct packed {
        status_t             status;
        logic [UNITS_W-1:0]  unit_count;
        logic [SCALAR_W-1:0] scalar_value;
        logic                char_done;
        logic                string_end;
    } result_t;

    // smallest code point allowed for a given sequence length
    function automatic logic [SCALAR_W-1:0] min_for_length(input logic [SEQLEN_W-1:0] len);
        logic [SCALAR_W-1:0] min_val;
        case (len)
            3'd2:    min_val = 21'h000080;
            3'd3:    min_val = 21'h000800;
            3'd4:    min_val = 21'h010000;
            default: min_val = '0;
        endcase
        return min_val;
    endfunction

endpackage

@@ rtl/utf8v_in_reg.sv @@
// input register stage holding one accepted byte
module utf8v_in_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [utf8v_pkg::BYTE_W-1:0]   s_axis_tdata,
    input  logic                           s_axis_tlast,
    input  logic                           advance,
    output logic                           item_valid,
    output utf8v_pkg::in_item_t            item
);
    import utf8v_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // take a new byte when empty or when the held one moves on this cycle
    assign s_axis_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.data_byte <= s_axis_tdata;
            item_reg.last_byte <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/utf8v_decode.sv @@
// one-byte step of the utf-8 decoder, validator and utf-16 unit counter
module utf8v_decode (
    input  utf8v_pkg::str_state_t              st,
    input  utf8v_pkg::in_item_t                item,
    input  logic [utf8v_pkg::UNITS_W-1:0]      max_units,
    output utf8v_pkg::str_state_t              st_next,
    output utf8v_pkg::result_t                 result
);
    import utf8v_pkg::*;

    logic [BYTE_W-1:0]   b;
    logic                complete;
    logic [SCALAR_W-1:0] cp;
    logic                bad_scalar;
    logic [UNITS_W:0]    sum;
    status_t             status;
    logic [SCALAR_W-1:0] scalar;
    logic                done;
    str_state_t          upd;

    assign b = item.data_byte;

    always_comb
    begin
        upd        = st;
        status     = ST_OK;
        scalar     = '0;
        done       = 1'b0;
        complete   = 1'b0;
        cp         = '0;
        bad_scalar = 1'b0;
        sum        = '0;

        // lead or continuation byte
        if (st.failed)
        begin
            status = ST_DISCARD;
        end
        else if (st.pending == '0)
        begin
            if (b[7] == 1'b0)
            begin
                upd.partial = {{(SCALAR_W-7){1'b0}}, b[6:0]};
                upd.seq_len = 3'd1;
                complete    = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                upd.partial = {{(SCALAR_W-5){1'b0}}, b[4:0]};
                upd.seq_len = 3'd2;
                upd.pending = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                upd.partial = {{(SCALAR_W-4){1'b0}}, b[3:0]};
                upd.seq_len = 3'd3;
                upd.pending = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                upd.partial = {{(SCALAR_W-3){1'b0}}, b[2:0]};
                upd.seq_len = 3'd4;
                upd.pending = 2'd3;
            end
            else
            begin
                status     = ST_BAD_LEAD;
                upd.failed = 1'b1;
            end
        end
        else
        begin
            if (b[7:6] != 2'b10)
            begin
                status     = ST_BAD_CONT;
                upd.failed = 1'b1;
            end
            else
            begin
                upd.partial = {st.partial[SCALAR_W-7:0], b[5:0]};
                upd.pending = st.pending - 2'd1;
                complete    = (st.pending == 2'd1);
            end
        end

        // range checks and unit count on a finished code point
        if (complete)
        begin
            cp         = upd.partial;
            bad_scalar = (cp < min_for_length(upd.seq_len)) || (cp > SCALAR_MAX) ||
                         ((cp >= SURR_LOW) && (cp <= SURR_HIGH));
            if (bad_scalar)
            begin
                status     = ST_BAD_SCAL;
                upd.failed = 1'b1;
            end
            else
            begin
                sum       = {1'b0, st.units} + ((cp > BMP_MAX) ? 17'd2 : 17'd1);
                upd.units = sum[UNITS_W] ? UNITS_SAT : sum[UNITS_W-1:0];
                if (sum > {1'b0, max_units})
                begin
                    status     = ST_OVER;
                    upd.failed = 1'b1;
                end
                else
                begin
                    scalar = cp;
                    done   = 1'b1;
                end
            end
            upd.partial = '0;
            upd.seq_len = '0;
        end

        // end of string status
        if (item.last_byte && (status == ST_OK))
        begin
            status = (upd.pending != '0) ? ST_TRUNC : ST_DONE;
        end
    end

    assign result.status       = status;
    assign result.unit_count   = upd.units;
    assign result.scalar_value = scalar;
    assign result.char_done    = done;
    assign result.string_end   = item.last_byte;

    // every state entry clears after the final byte
    assign st_next = item.last_byte ? str_state_t'('0) : upd;

endmodule

@@ rtl/utf8_validate_utf16_count.sv @@
// top level of the utf-8 validator with utf-16 unit count
// Takes one UTF-8 byte per transaction (tlast on the final byte of a string) and returns one
// result per byte: status, UTF-16 units counted so far, the decoded code point with char_done,
// and tlast copied from the input. One byte is taken every clock cycle when the output side
// keeps up; each byte is held in the input register, then in the result register, with the whole
// decode step done in the logic between them. s_axis_tready follows m_axis_tready in the same
// cycle when both registers are full. The unit limit max_units (reset 50) is set by cfg_wr_en /
// cfg_wr_data; the user must write it only while no string is in flight; it is not enforced.
module utf8_validate_utf16_count (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config
    input  logic                                 cfg_wr_en,
    input  logic [utf8v_pkg::UNITS_W-1:0]        cfg_wr_data,      // max_units
    // byte stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [utf8v_pkg::IN_DATA_W-1:0]      s_axis_tdata,     // data_byte
    input  logic                                 s_axis_tlast,     // last_byte
    // result stream out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata fields from bit 0 up: status, unit_count, scalar_value, char_done, zero fill
    output logic [utf8v_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast      // string_end
);
    import utf8v_pkg::*;

    logic [UNITS_W-1:0]  max_units_val_reg;
    logic                item_valid;
    in_item_t            item;
    logic                advance;
    logic                out_free;
    str_state_t          state_reg;
    str_state_t          state_next;
    result_t             result;
    result_t             result_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    // unit limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_val_reg <= MAX_UNITS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_units_val_reg <= cfg_wr_data;
        end
    end

    // input register
    utf8v_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    // decode step
    utf8v_decode u_decode (
        .st        (state_reg),
        .item      (item),
        .max_units (max_units_val_reg),
        .st_next   (state_next),
        .result    (result)
    );

    // move a byte into the result register when it is empty or being drained
    assign out_free = !out_valid_reg || m_axis_tready;
    assign advance  = item_valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // string state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = result_reg.string_end;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                            result_reg.char_done,
                            result_reg.scalar_value,
                            result_reg.unit_count,
                            STATUS_W'(result_reg.status)};

endmodule

@@ rtl/utf8v_checker.sv @@
// port-level checks for the utf-8 validator, bound to the top level
module utf8v_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [utf8v_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                 m_axis_tlast
);
    import utf8v_pkg::*;

    localparam int CD_BIT = STATUS_W + UNITS_W + SCALAR_W;

    logic [STATUS_W-1:0] st_code;
    logic [SCALAR_W-1:0] scal;
    logic                cdone;

    assign st_code = m_axis_tdata[STATUS_W-1:0];
    assign scal    = m_axis_tdata[STATUS_W+UNITS_W +: SCALAR_W];
    assign cdone   = m_axis_tdata[CD_BIT];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a completed code point only comes with a good status
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cdone |-> (st_code == ST_OK) || (st_code == ST_DONE))
        else $error("char_done with error status");

    // no code point reported without char_done
    a_scalar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !cdone |-> scal == '0)
        else $error("scalar_value nonzero without char_done");

    // end-of-string codes only on the final byte
    a_end_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((st_code == ST_DONE) || (st_code == ST_TRUNC)) |-> m_axis_tlast)
        else $error("string end status without tlast");

endmodule

bind utf8_validate_utf16_count utf8v_checker u_utf8v_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the utf-8 validator with utf-16 unit count
module tb;
    import utf8v_pkg::*;

    typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

    // one line of the directed stimulus
    typedef struct {
        row_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [UNITS_W-1:0] limit;
        logic               typed;
        result_t            want;
    } stim_row_t;

    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 125;
    localparam int MAX_PRINTED = 100;
    localparam int SUPP_CHARS  = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [UNITS_W-1:0]    cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;     // data_byte
    logic                  s_axis_tlast = 1'b0;   // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // status, unit_count, scalar_value, char_done
    logic                  m_axis_tlast;          // string_end

    // fixed expectation riding along with the offered byte
    logic    typed_valid = 1'b0;
    result_t typed_result = '0;

    // decoder state mirrored for prediction
    logic [PEND_W-1:0]   pend_bytes = '0;
    logic [SEQLEN_W-1:0] seq_bytes = '0;
    logic [SCALAR_W-1:0] partial_cp = '0;
    logic [UNITS_W-1:0]  unit_total = '0;
    logic                str_failed = 1'b0;
    logic [UNITS_W-1:0]  unit_limit = MAX_UNITS_RESET;

    result_t           byte_results_q[$];
    logic [BYTE_W-1:0] str_bytes[$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_left = 0;
    int                mismatch_count = 0;

    utf8_validate_utf16_count u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // decode one byte and return the result the block should give for it
    function automatic result_t validate_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_t             r;
        status_t             st;
        logic                complete;
        logic [SCALAR_W-1:0] lo;
        logic [UNITS_W:0]    sum;
        r = '0;
        st = ST_OK;
        complete = 1'b0;
        if (str_failed)
            st = ST_DISCARD;
        else if (pend_bytes == '0)
        begin
            if (b[7] == 1'b0)
            begin
                partial_cp = SCALAR_W'(b);
                seq_bytes = 3'd1;
                complete = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                partial_cp = SCALAR_W'(b[4:0]);
                seq_bytes = 3'd2;
                pend_bytes = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial_cp = SCALAR_W'(b[3:0]);
                seq_bytes = 3'd3;
                pend_bytes = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                partial_cp = SCALAR_W'(b[2:0]);
                seq_bytes = 3'd4;
                pend_bytes = 2'd3;
            end
            else
            begin
                st = ST_BAD_LEAD;
                str_failed = 1'b1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            st = ST_BAD_CONT;
            str_failed = 1'b1;
        end
        else
        begin
            partial_cp = {partial_cp[SCALAR_W-7:0], b[5:0]};
            pend_bytes = pend_bytes - 2'd1;
            complete = (pend_bytes == '0);
        end

        // range, overlong and surrogate checks, then the unit count
        if (complete)
        begin
            case (seq_bytes)
                3'd2:    lo = 21'h000080;
                3'd3:    lo = 21'h000800;
                3'd4:    lo = 21'h010000;
                default: lo = '0;
            endcase
            if (partial_cp < lo || partial_cp > SCALAR_MAX ||
                (partial_cp >= SURR_LOW && partial_cp <= SURR_HIGH))
            begin
                st = ST_BAD_SCAL;
                str_failed = 1'b1;
            end
            else
            begin
                sum = {1'b0, unit_total} + ((partial_cp > BMP_MAX) ? 17'd2 : 17'd1);
                unit_total = sum[UNITS_W] ? UNITS_SAT : sum[UNITS_W-1:0];
                if (sum > {1'b0, unit_limit})
                begin
                    st = ST_OVER;
                    str_failed = 1'b1;
                end
                else
                begin
                    r.scalar_value = partial_cp;
                    r.char_done = 1'b1;
                end
            end
            partial_cp = '0;
            seq_bytes = '0;
        end

        if (last && st == ST_OK)
            st = (pend_bytes != '0) ? ST_TRUNC : ST_DONE;
        r.status = st;
        r.unit_count = unit_total;
        r.string_end = last;

        if (last)
        begin
            pend_bytes = '0;
            seq_bytes = '0;
            partial_cp = '0;
            unit_total = '0;
            str_failed = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // predict each accepted input transaction
    always @(posedge clk)
    begin
        result_t predicted;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predicted = validate_byte(s_axis_tdata, s_axis_tlast);
            byte_results_q.insert(byte_results_q.size(),
                                  typed_valid ? typed_result : predicted);
        end
    end

    // check each accepted output transaction against the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status       = status_t'(m_axis_tdata[STATUS_W-1:0]);
            got.unit_count   = m_axis_tdata[STATUS_W +: UNITS_W];
            got.scalar_value = m_axis_tdata[STATUS_W + UNITS_W +: SCALAR_W];
            got.char_done    = m_axis_tdata[STATUS_W + UNITS_W + SCALAR_W];
            got.string_end   = m_axis_tlast;
            if (byte_results_q.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, 0);
            else
            begin
                want = byte_results_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.unit_count !== want.unit_count)
                    report_mismatch("unit_count", got.unit_count, want.unit_count);
                if (got.scalar_value !== want.scalar_value)
                    report_mismatch("scalar_value", got.scalar_value, want.scalar_value);
                if (got.char_done !== want.char_done)
                    report_mismatch("char_done", got.char_done, want.char_done);
                if (got.string_end !== want.string_end)
                    report_mismatch("string_end", got.string_end, want.string_end);
            end
        end
    end

    // output backpressure, with an optional long hold
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one byte and wait for its handshake
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic last,
                              input logic has_typed, input result_t typed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        typed_valid   <= has_typed;
        typed_result  <= typed;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (byte_results_q.size() == 0);
    endtask

    task automatic set_unit_limit(input logic [UNITS_W-1:0] value);
        wait_results_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        unit_limit = value;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            offer_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
    endtask

    // append one byte to the string being built
    function automatic void add_str_byte(input logic [BYTE_W-1:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // utf-8 encoding of cp in len bytes, overlong or out of range allowed
    function automatic void encode_scalar(input logic [SCALAR_W-1:0] cp, input int len);
        case (len)
            1:
                add_str_byte({1'b0, cp[6:0]});
            2:
            begin
                add_str_byte({3'b110, cp[10:6]});
                add_str_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_str_byte({4'b1110, cp[15:12]});
                add_str_byte({2'b10, cp[11:6]});
                add_str_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_str_byte({5'b11110, cp[20:18]});
                add_str_byte({2'b10, cp[17:12]});
                add_str_byte({2'b10, cp[11:6]});
                add_str_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [SCALAR_W-1:0] pick_valid_scalar(input int len);
        case (len)
            1:       return SCALAR_W'($urandom_range('h7F));
            2:       return SCALAR_W'($urandom_range('h7FF, 'h80));
            3:       return $urandom_range(1) ? SCALAR_W'($urandom_range('hD7FF, 'h800))
                                              : SCALAR_W'($urandom_range('hFFFF, 'hE000));
            default: return SCALAR_W'($urandom_range('h10FFFF, 'h10000));
        endcase
    endfunction

    // mostly well-formed characters, with errors mixed in
    task automatic build_random_string();
        int                  n_chars;
        int                  pick;
        int                  len;
        int                  at;
        logic [SCALAR_W-1:0] top;
        str_bytes.delete();
        n_chars = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
        for (int c = 0; c < n_chars; c++)
        begin
            pick = $urandom_range(99);
            len = $urandom_range(4, 1);
            if (pick < 80)
                encode_scalar(pick_valid_scalar(len), len);
            else if (pick < 84)
                add_str_byte(8'($urandom_range(255)));
            else if (pick < 87)
                // stray continuation, or a lead no sequence length allows
                add_str_byte($urandom_range(1) ? 8'($urandom_range('hBF, 'h80))
                                               : 8'($urandom_range('hFF, 'hF8)));
            else if (pick < 90)
            begin
                // overlong form
                len = $urandom_range(4, 2);
                top = (len == 2) ? 21'h7F : (len == 3) ? 21'h7FF : 21'hFFFF;
                encode_scalar(SCALAR_W'($urandom_range(top)), len);
            end
            else if (pick < 93)
                encode_scalar(SCALAR_W'($urandom_range('hDFFF, 'hD800)), 3);
            else if (pick < 95)
                encode_scalar(SCALAR_W'($urandom_range('h1FFFFF, 'h110000)), 4);
            else
            begin
                // a continuation slot holds something else
                len = $urandom_range(4, 2);
                at = str_bytes.size() + $urandom_range(len - 1, 1);
                encode_scalar(pick_valid_scalar(len), len);
                str_bytes[at] = $urandom_range(1) ? 8'($urandom_range('h7F))
                                                  : 8'($urandom_range('hFF, 'hC0));
            end
        end
        // sometimes the string stops inside a sequence
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(4, 2);
            encode_scalar(pick_valid_scalar(len), len);
            repeat ($urandom_range(len - 1, 1))
                void'(str_bytes.pop_back());
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [UNITS_W-1:0] limit, input bit pause_mid);
        int phase_bytes;
        bit paused;
        phase_bytes = 0;
        paused = 1'b0;
        set_unit_limit(limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (phase_bytes < PHASE_BYTES)
        begin
            if (pause_mid && !paused && phase_bytes >= PHASE_BYTES / 2)
            begin
                wait_results_drained();
                paused = 1'b1;
            end
            build_random_string();
            send_string();
            phase_bytes += str_bytes.size();
        end
    endtask

    function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] b, input logic last);
        stim_row_t row;
        row.kind  = ROW_BYTE;
        row.data  = b;
        row.last  = last;
        row.limit = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [BYTE_W-1:0] b, input logic last,
                                            input status_t st, input logic [UNITS_W-1:0] units,
                                            input logic [SCALAR_W-1:0] cp, input logic done);
        stim_row_t row;
        row = byte_row(b, last);
        row.typed = 1'b1;
        row.want = '{st, units, cp, done, last};
        return row;
    endfunction

    // stimulus
    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // ascii extremes under the reset limit
        rows.insert(rows.size(), typed_row(8'h00, 1'b0, ST_OK, 16'd1, 21'h0, 1'b1));
        rows.insert(rows.size(), typed_row(8'h7F, 1'b1, ST_DONE, 16'd2, 21'h7F, 1'b1));
        // smallest two-byte and largest four-byte code points
        rows.insert(rows.size(), byte_row(8'hC2, 1'b0));
        rows.insert(rows.size(), byte_row(8'h80, 1'b1));
        rows.insert(rows.size(), byte_row(8'hF4, 1'b0));
        rows.insert(rows.size(), byte_row(8'h8F, 1'b0));
        rows.insert(rows.size(), byte_row(8'hBF, 1'b0));
        rows.insert(rows.size(), byte_row(8'hBF, 1'b1));
        // bad lead, then the rest discarded
        rows.insert(rows.size(), typed_row(8'h80, 1'b0, ST_BAD_LEAD, 16'd0, 21'h0, 1'b0));
        rows.insert(rows.size(), typed_row(8'h41, 1'b1, ST_DISCARD, 16'd0, 21'h0, 1'b0));
        // bad lead on the final byte
        rows.insert(rows.size(), typed_row(8'hFF, 1'b1, ST_BAD_LEAD, 16'd0, 21'h0, 1'b0));
        // overlong through a C0 lead
        rows.insert(rows.size(), byte_row(8'hC0, 1'b0));
        rows.insert(rows.size(), typed_row(8'h80, 1'b1, ST_BAD_SCAL, 16'd0, 21'h0, 1'b0));
        // surrogate
        rows.insert(rows.size(), byte_row(8'hED, 1'b0));
        rows.insert(rows.size(), byte_row(8'hA0, 1'b0));
        rows.insert(rows.size(), typed_row(8'h80, 1'b1, ST_BAD_SCAL, 16'd0, 21'h0, 1'b0));
        // above the top of the code space through an F5 lead
        rows.insert(rows.size(), byte_row(8'hF5, 1'b0));
        rows.insert(rows.size(), byte_row(8'h80, 1'b0));
        rows.insert(rows.size(), byte_row(8'h80, 1'b0));
        rows.insert(rows.size(), typed_row(8'h80, 1'b1, ST_BAD_SCAL, 16'd0, 21'h0, 1'b0));
        // bad continuation on the final byte
        rows.insert(rows.size(), byte_row(8'hC2, 1'b0));
        rows.insert(rows.size(), typed_row(8'h41, 1'b1, ST_BAD_CONT, 16'd0, 21'h0, 1'b0));
        // string cut short
        rows.insert(rows.size(), byte_row(8'hE2, 1'b0));
        rows.insert(rows.size(), typed_row(8'h82, 1'b1, ST_TRUNC, 16'd0, 21'h0, 1'b0));
        // zero limit: the first character is already over
        row = byte_row(8'h00, 1'b0);
        row.kind = ROW_LIMIT;
        row.limit = 16'd0;
        rows.insert(rows.size(), row);
        rows.insert(rows.size(), typed_row(8'h41, 1'b1, ST_OVER, 16'd1, 21'h0, 1'b0));

        send_idle_pct = 12;
        recv_idle_pct = 53;
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_LIMIT)
                set_unit_limit(rows[i].limit);
            else
                offer_byte(rows[i].data, rows[i].last, rows[i].typed, rows[i].want);
        end

        // random strings over several limits and idle patterns
        run_random_phase(12, 53, 16'($urandom_range(30, 4)), 1'b0);
        run_random_phase(12, 53, 16'd0, 1'b1);
        run_random_phase(53, 12, UNITS_SAT, 1'b0);
        run_random_phase(53, 12, 16'($urandom_range(16'hFFFF)), 1'b0);

        // one long string of mostly supplementary characters behind a long output hold
        set_unit_limit(UNITS_SAT);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        str_bytes.delete();
        repeat (SUPP_CHARS)
            encode_scalar(21'h10000, 4);
        encode_scalar(21'h41, 1);
        encode_scalar(SCALAR_MAX, 4);
        hold_left = HOLD_CYCLES;
        send_string();

        run_random_phase(0, 0, UNITS_SAT, 1'b0);
        run_random_phase(0, 0, 16'($urandom_range(12, 1)), 1'b0);

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("utf8_validate_utf16_count regression: pass");
        else
            $display("utf8_validate_utf16_count regression: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("utf8_validate_utf16_count regression: fail");
        $finish;
    end

endmodule

@@ utf8_validate_utf16_count.f @@
rtl/utf8v_pkg.sv
rtl/utf8v_in_reg.sv
rtl/utf8v_decode.sv
rtl/utf8_validate_utf16_count.sv
rtl/utf8v_checker.sv
tb/tb.sv
